FILE: hw/rtl/thick_line_quad_expander_core_defines.svh
// Assertion macros used by the emit module of the line expander.
`ifndef THICK_LINE_QUAD_EXPANDER_CORE_DEFINES_SVH
`define THICK_LINE_QUAD_EXPANDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TLQX_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlqx assertion failed");
`define TLQX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlqx assertion failed");
`else
`define TLQX_ASSERT_SAME(label, ante, cons)
`define TLQX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/tlqx_pkg.sv
// Shared types and constants of the thick line quad expander.
`timescale 1ns / 1ps
package tlqx_pkg;

  localparam int InWidth   = 112;
  localparam int OutWidth  = 64;
  localparam int DivBits   = 24;
  localparam int RootBits  = 12;
  localparam int NumVerts  = 6;

  // Per vertex: take the end point, and add the offset.
  localparam logic [NumVerts-1:0] UseEnd  = 6'b010110;
  localparam logic [NumVerts-1:0] AddOffs = 6'b001011;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
    logic [31:0] color;
    logic        negx;
    logic        negy;
    logic        zero;
  } item_t;

  typedef struct packed {
    item_t       it;
    logic [33:0] s;
    logic [55:0] rx;
    logic [55:0] ry;
    logic [DivBits-1:0] qx;
    logic [DivBits-1:0] qy;
    logic        satx;
    logic        saty;
  } div_t;

  typedef struct packed {
    item_t       it;
    logic [DivBits-1:0]  qx;
    logic [DivBits-1:0]  qy;
    logic [RootBits-1:0] rtx;
    logic [RootBits-1:0] rty;
  } sq_t;

endpackage

FILE: hw/rtl/tlqx_setup.sv
// Front stages: differences, products, squared lengths and quotient range check.
`timescale 1ns / 1ps
module tlqx_setup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tlqx_pkg::InWidth-1:0]  in_data,
  output logic                          out_valid,
  output tlqx_pkg::div_t                out_d
);

  logic va, vb, vc;
  tlqx_pkg::item_t a_it, b_it, c_it, c_it_next;
  logic signed [16:0] a_dx, a_dy;
  logic [11:0] a_w;
  logic signed [29:0] b_px, b_py;
  logic [32:0] b_xx, b_yy;
  logic [55:0] c_n2x, c_n2y;
  logic [33:0] c_s;
  logic signed [29:0] magx_s, magy_s;
  logic signed [33:0] sqx, sqy;
  logic signed [29:0] px_p, py_p;

  // Valid bits follow the data through every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      out_valid <= vc;
    end
  end

  assign px_p = a_dy * $signed({1'b0, a_w});
  assign py_p = a_dx * $signed({1'b0, a_w});
  assign sqx  = a_dx * a_dx;
  assign sqy  = a_dy * a_dy;
  assign magx_s = b_px[29] ? -b_px : b_px;
  assign magy_s = b_py[29] ? -b_py : b_py;

  // Offset signs and the zero length flag join the item for stage three.
  always_comb begin
    c_it_next      = b_it;
    c_it_next.negx = !b_px[29] && (b_px != '0);
    c_it_next.negy = b_py[29];
    c_it_next.zero = (b_xx == '0) && (b_yy == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage one: unpack and take the endpoint differences.
      a_it.sx    <= in_data[15:0];
      a_it.sy    <= in_data[31:16];
      a_it.ex    <= in_data[47:32];
      a_it.ey    <= in_data[63:48];
      a_it.color <= in_data[107:76];
      a_it.negx  <= 1'b0;
      a_it.negy  <= 1'b0;
      a_it.zero  <= 1'b0;
      a_w  <= in_data[75:64];
      a_dx <= $signed({in_data[47], in_data[47:32]}) - $signed({in_data[15], in_data[15:0]});
      a_dy <= $signed({in_data[63], in_data[63:48]}) - $signed({in_data[31], in_data[31:16]});
      // Stage two: offset numerators and squared components.
      b_it <= a_it;
      b_px <= px_p;
      b_py <= py_p;
      b_xx <= sqx[32:0];
      b_yy <= sqy[32:0];
      // Stage three: squared numerators and squared length.
      c_it  <= c_it_next;
      c_n2x <= magx_s[27:0] * magx_s[27:0];
      c_n2y <= magy_s[27:0] * magy_s[27:0];
      c_s   <= {1'b0, b_xx} + {1'b0, b_yy};
      // Stage four: quotient that would not fit in its width saturates.
      out_d.it   <= c_it;
      out_d.s    <= c_s;
      out_d.rx   <= c_n2x;
      out_d.ry   <= c_n2y;
      out_d.qx   <= '0;
      out_d.qy   <= '0;
      out_d.satx <= {2'b0, c_n2x} >= {c_s, 24'b0};
      out_d.saty <= {2'b0, c_n2y} >= {c_s, 24'b0};
    end
  end

endmodule

FILE: hw/rtl/tlqx_div_stage.sv
// One restoring division step for both offset components.
`timescale 1ns / 1ps
module tlqx_div_stage #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  tlqx_pkg::div_t in_d,
  output logic           out_valid,
  output tlqx_pkg::div_t out_d
);

  logic [56:0] dsh;
  logic fitx, fity;
  tlqx_pkg::div_t nxt;

  // Compare each remainder with the shifted length and subtract on a fit.
  always_comb begin
    dsh  = 57'(in_d.s) << BIT;
    fitx = {1'b0, in_d.rx} >= dsh;
    fity = {1'b0, in_d.ry} >= dsh;
    nxt  = in_d;
    if (fitx) begin
      nxt.rx = in_d.rx - dsh[55:0];
    end
    if (fity) begin
      nxt.ry = in_d.ry - dsh[55:0];
    end
    nxt.qx[BIT] = fitx;
    nxt.qy[BIT] = fity;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= nxt;
    end
  end

endmodule

FILE: hw/rtl/tlqx_sqrt_stage.sv
// One integer square root step for both offset components.
`timescale 1ns / 1ps
module tlqx_sqrt_stage #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  tlqx_pkg::sq_t in_d,
  output logic          out_valid,
  output tlqx_pkg::sq_t out_d
);

  logic [tlqx_pkg::RootBits-1:0] candx, candy;
  logic [tlqx_pkg::DivBits-1:0] sqx, sqy;
  tlqx_pkg::sq_t nxt;

  // Keep the trial bit when its square stays within the quotient.
  always_comb begin
    candx = in_d.rtx | (tlqx_pkg::RootBits'(1) << BIT);
    candy = in_d.rty | (tlqx_pkg::RootBits'(1) << BIT);
    sqx   = candx * candx;
    sqy   = candy * candy;
    nxt   = in_d;
    if (sqx <= in_d.qx) begin
      nxt.rtx = candx;
    end
    if (sqy <= in_d.qy) begin
      nxt.rty = candy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= nxt;
    end
  end

endmodule

FILE: hw/rtl/tlqx_emit.sv
// Output register and six vertex sequencer.
`timescale 1ns / 1ps
`include "thick_line_quad_expander_core_defines.svh"
module tlqx_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tlqx_pkg::sq_t                  in_d,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tlqx_pkg::OutWidth-1:0]  m_tdata,  // vertex_x, vertex_y, red, green, blue, alpha
  output logic                           m_tlast   // last_vertex
);

  tlqx_pkg::item_t it;
  logic signed [12:0] ox, oy;
  logic [2:0] cnt;
  logic load;
  logic [12:0] mx, my;
  logic signed [16:0] bx, by, vx, vy;
  logic [15:0] satx, saty;

  assign in_ready = !m_tvalid || (m_tready && cnt == 3'd5);
  assign load     = in_valid && in_ready && !in_d.it.zero;

  // Half of the root, rounded up, is the offset magnitude.
  assign mx = ({1'b0, in_d.rtx} + 13'd1) >> 1;
  assign my = ({1'b0, in_d.rty} + 13'd1) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          m_tvalid <= 1'b0;
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
        cnt      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      it <= in_d.it;
      ox <= in_d.it.negx ? -$signed(mx) : $signed(mx);
      oy <= in_d.it.negy ? -$signed(my) : $signed(my);
    end
  end

  // Pick the endpoint and offset sign of the current vertex, then saturate.
  always_comb begin
    bx = tlqx_pkg::UseEnd[cnt] ? $signed({it.ex[15], it.ex}) : $signed({it.sx[15], it.sx});
    by = tlqx_pkg::UseEnd[cnt] ? $signed({it.ey[15], it.ey}) : $signed({it.sy[15], it.sy});
    vx = tlqx_pkg::AddOffs[cnt] ? bx + 17'(ox) : bx - 17'(ox);
    vy = tlqx_pkg::AddOffs[cnt] ? by + 17'(oy) : by - 17'(oy);
    satx = (vx[16] != vx[15]) ? {vx[16], {15{!vx[16]}}} : vx[15:0];
    saty = (vy[16] != vy[15]) ? {vy[16], {15{!vy[16]}}} : vy[15:0];
  end

  assign m_tdata = {it.color, saty, satx};
  assign m_tlast = (cnt == 3'd5);

  `TLQX_ASSERT_SAME(a_cnt_range, m_tvalid, cnt <= 3'd5)
  `TLQX_ASSERT_SAME(a_ready_busy, !in_ready, m_tvalid)
  `TLQX_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, $stable(cnt) && m_tvalid)
  `TLQX_ASSERT_NEXT(a_end_run, m_tvalid && m_tready && m_tlast && !load, !m_tvalid)

endmodule

FILE: hw/rtl/thick_line_quad_expander_core.sv
// Top level of the thick line quad expander.
`timescale 1ns / 1ps
// Each accepted segment word gives six vertex words (two triangles), the
// sixth marked by tlast; a segment with equal endpoints gives none. The
// offset is computed through a 41-stage pipeline (four setup stages, 24
// restoring division steps, 12 square root steps, one output register).
// Throughput is bounded by the single vertex output port, which sends a
// segment's six vertices one after another. The pipeline moves, and takes
// a new segment, whenever its last stage is empty or the output register
// frees up, and holds everything while a segment waits in its last stage.
module thick_line_quad_expander_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // start_x, start_y, end_x, end_y, line_width, red, green, blue, alpha
  input  logic [tlqx_pkg::InWidth-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // vertex_x, vertex_y, red, green, blue, alpha
  output logic [tlqx_pkg::OutWidth-1:0]  m_tdata,
  output logic                           m_tlast  // last_vertex
);

  localparam int NDiv = tlqx_pkg::DivBits;
  localparam int NSq  = tlqx_pkg::RootBits;

  logic en, emit_ready;
  logic div_v [0:NDiv];
  tlqx_pkg::div_t div_d [0:NDiv];
  logic sq_v [0:NSq];
  tlqx_pkg::sq_t sq_d [0:NSq];

  // The whole pipeline moves together unless its last stage is held.
  assign en       = !sq_v[NSq] || emit_ready;
  assign s_tready = en;

  tlqx_setup u_setup (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_data(s_tdata),
    .out_valid(div_v[0]), .out_d(div_d[0])
  );

  genvar k;
  generate
    for (k = 0; k < NDiv; k++) begin : g_div
      tlqx_div_stage #(.BIT(NDiv - 1 - k)) u_div (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(div_v[k]), .in_d(div_d[k]),
        .out_valid(div_v[k+1]), .out_d(div_d[k+1])
      );
    end
  endgenerate

  // Saturated quotients take the largest value the root stages handle.
  always_comb begin
    sq_v[0]    = div_v[NDiv];
    sq_d[0].it = div_d[NDiv].it;
    sq_d[0].qx = div_d[NDiv].satx ? '1 : div_d[NDiv].qx;
    sq_d[0].qy = div_d[NDiv].saty ? '1 : div_d[NDiv].qy;
    sq_d[0].rtx = '0;
    sq_d[0].rty = '0;
  end

  generate
    for (k = 0; k < NSq; k++) begin : g_sq
      tlqx_sqrt_stage #(.BIT(NSq - 1 - k)) u_sq (
        .clk(clk), .rst(rst), .en(en),
        .in_valid(sq_v[k]), .in_d(sq_d[k]),
        .out_valid(sq_v[k+1]), .out_d(sq_d[k+1])
      );
    end
  endgenerate

  tlqx_emit u_emit (
    .clk(clk), .rst(rst),
    .in_valid(sq_v[NSq]), .in_ready(emit_ready), .in_d(sq_d[NSq]),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule
